>>> rtl/core/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

   // Field widths of the command, result and control/status channels.
   localparam int CHAR_W     = 8;
   localparam int ATTR_W     = 8;
   localparam int ROW_FW     = 5;
   localparam int COL_FW     = 7;
   localparam int TAB_W      = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   // Character codes with special handling.
   localparam logic [CHAR_W-1:0] CH_NUL     = 8'd0;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
   localparam logic [CHAR_W-1:0] CH_DOT     = 8'd46;

   // Command codes.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // Control register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] CSR_ATTRIBUTE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAB_SPACES = 1'd1;
   localparam logic [ATTR_W-1:0]    ATTR_RESET     = 8'd15;
   localparam logic [TAB_W-1:0]     TAB_RESET      = 4'd8;

   // One screen cell: attribute in the high byte, character in the low byte.
   typedef struct packed {
      logic [ATTR_W-1:0] attr;
      logic [CHAR_W-1:0] chr;
   } cell_type;

endpackage

`default_nettype wire

>>> rtl/core/tcw_ram.sv
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one read port with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/core/text_console_writer.sv
`default_nettype none

// A printable byte, a zero byte or a tab of zero spaces answers straight from the idle state;
// a tab of N spaces once the tab state has placed its N spaces; a read after the read state;
// a newline after the copy sweep and drain state, plus the hidden-row clear when the buffer
// scrolls. The newline time is set by the copy sweep, one cell per cycle through the shadow
// memory's single read port. One command is in work at a time; the response strobe is one cycle
// wide and cannot be stalled. After reset, busy stays high while both memories are swept to zero.
module text_console_writer #(
   parameter int SCREEN_ROWS = 25,
   parameter int SCREEN_COLS = 80
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic                         req_command,
   input  wire logic [tcw_pkg::CHAR_W-1:0]   req_char_code,
   input  wire logic [tcw_pkg::ROW_FW-1:0]   req_read_row,
   input  wire logic [tcw_pkg::COL_FW-1:0]   req_read_col,
   output logic                              rsp_valid,
   output logic      [tcw_pkg::CHAR_W-1:0]   rsp_cell_char,
   output logic      [tcw_pkg::ATTR_W-1:0]   rsp_cell_attribute,
   output logic      [tcw_pkg::ROW_FW-1:0]   rsp_cursor_row,
   output logic      [tcw_pkg::COL_FW-1:0]   rsp_cursor_col,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [tcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tcw_pkg::CSR_DATA_W-1:0] csr_data
);

   import tcw_pkg::*;

   localparam int SHADOW_CELLS  = (SCREEN_ROWS + 1) * SCREEN_COLS;
   localparam int VISIBLE_CELLS = SCREEN_ROWS * SCREEN_COLS;
   localparam int SA_W  = $clog2(SHADOW_CELLS);
   localparam int DA_W  = $clog2(VISIBLE_CELLS);
   localparam int CNT_W = $clog2(SHADOW_CELLS + 1);
   localparam int ROW_W = $clog2(SCREEN_ROWS + 1);
   localparam int COL_W = $clog2(SCREEN_COLS);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_TAB   = 3'd2;
   localparam logic [2:0] ST_COPY  = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_HCLR  = 3'd5;
   localparam logic [2:0] ST_READ  = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ATTR_W-1:0] attr_ff, attr_in;
   logic [TAB_W-1:0]  tabs_ff, tabs_in;
   logic [TAB_W-1:0]  tab_left_ff, tab_left_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              scroll_ff, scroll_in;
   logic              in_range_ff, in_range_in;
   logic              pv_ff, pv_in;
   logic [DA_W-1:0]   pa_ff, pa_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic [ATTR_W-1:0] rsp_attr_ff, rsp_attr_in;
   logic [ROW_FW-1:0] rsp_row_ff, rsp_row_in;
   logic [COL_FW-1:0] rsp_col_ff, rsp_col_in;

   logic              accept;
   logic              put_active;
   logic              put_store;
   logic [CHAR_W-1:0] put_char;
   logic              respond;

   logic              sh_wr_en;
   logic [SA_W-1:0]   sh_wr_addr;
   cell_type          sh_wr_data;
   logic [SA_W-1:0]   sh_rd_addr;
   cell_type          sh_rd_data;
   logic              dp_wr_en;
   logic [DA_W-1:0]   dp_wr_addr;
   cell_type          dp_wr_data;
   logic [DA_W-1:0]   dp_rd_addr;
   cell_type          dp_rd_data;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // Shadow buffer: visible rows plus the hidden row below them.
   tcw_ram #(
      .WIDTH ($bits(cell_type)),
      .DEPTH (SHADOW_CELLS)
   ) u_shadow_ram (
      .clock   (clock),
      .wr_en   (sh_wr_en),
      .wr_addr (sh_wr_addr),
      .wr_data (sh_wr_data),
      .rd_addr (sh_rd_addr),
      .rd_data (sh_rd_data)
   );

   // Display memory: what read commands see.
   tcw_ram #(
      .WIDTH ($bits(cell_type)),
      .DEPTH (VISIBLE_CELLS)
   ) u_display_ram (
      .clock   (clock),
      .wr_en   (dp_wr_en),
      .wr_addr (dp_wr_addr),
      .wr_data (dp_wr_data),
      .rd_addr (dp_rd_addr),
      .rd_data (dp_rd_data)
   );

   // Character placement at the cursor, with the dot in the next-to-last column.
   always_comb begin
      put_active = (state_ff == ST_TAB) ||
                   (accept && (req_command == CMD_WRITE) && (req_char_code != CH_NEWLINE) &&
                    (req_char_code != CH_TAB) && (req_char_code != CH_NUL));
      put_store  = (col_ff <= COL_W'(SCREEN_COLS - 2));
      if (col_ff == COL_W'(SCREEN_COLS - 2)) begin
         put_char = CH_DOT;
      end else if (state_ff == ST_TAB) begin
         put_char = CH_SPACE;
      end else begin
         put_char = req_char_code;
      end
   end

   // Memory port steering for the clearing pass, character writes, the copy sweep and the hidden-row clear.
   always_comb begin
      sh_wr_en   = 1'b0;
      sh_wr_addr = SA_W'(row_ff * SCREEN_COLS + col_ff);
      sh_wr_data = '{attr: attr_ff, chr: put_char};
      sh_rd_addr = SA_W'(cnt_ff + (scroll_ff ? SCREEN_COLS : 0));
      dp_wr_en   = 1'b0;
      dp_wr_addr = pa_ff;
      dp_wr_data = sh_rd_data;
      dp_rd_addr = DA_W'(req_read_row * SCREEN_COLS + req_read_col);
      case (state_ff)
         ST_CLEAR: begin
            sh_wr_en   = 1'b1;
            sh_wr_addr = cnt_ff[SA_W-1:0];
            sh_wr_data = '0;
            dp_wr_en   = (cnt_ff < CNT_W'(VISIBLE_CELLS));
            dp_wr_addr = cnt_ff[DA_W-1:0];
            dp_wr_data = '0;
         end
         ST_HCLR: begin
            sh_wr_en   = 1'b1;
            sh_wr_addr = cnt_ff[SA_W-1:0];
            sh_wr_data = '0;
         end
         ST_COPY, ST_DRAIN: begin
            sh_wr_en   = pv_ff && scroll_ff;
            sh_wr_addr = SA_W'(pa_ff);
            sh_wr_data = sh_rd_data;
            dp_wr_en   = pv_ff;
         end
         ST_IDLE, ST_TAB: begin
            sh_wr_en = put_active && put_store;
         end
         default: begin
         end
      endcase
   end

   // Command sequencer.
   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      tab_left_in = tab_left_ff;
      cnt_in      = cnt_ff;
      scroll_in   = scroll_ff;
      in_range_in = in_range_ff;
      pv_in       = (state_ff == ST_COPY);
      pa_in       = cnt_ff[DA_W-1:0];
      respond     = 1'b0;
      rsp_char_in = '0;
      rsp_attr_in = '0;

      if (put_active && (col_ff < COL_W'(SCREEN_COLS - 1))) begin
         col_in = col_ff + 1'b1;
      end

      case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SHADOW_CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_READ) begin
                  in_range_in = (req_read_row < SCREEN_ROWS) && (req_read_col < SCREEN_COLS);
                  state_in    = ST_READ;
               end else if (req_char_code == CH_NEWLINE) begin
                  scroll_in = (row_ff >= ROW_W'(SCREEN_ROWS));
                  if (row_ff < ROW_W'(SCREEN_ROWS)) begin
                     row_in = row_ff + 1'b1;
                  end
                  col_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_COPY;
               end else if ((req_char_code == CH_TAB) && (tabs_ff != '0)) begin
                  tab_left_in = tabs_ff;
                  state_in    = ST_TAB;
               end else begin
                  respond = 1'b1;
               end
            end
         end
         ST_TAB: begin
            tab_left_in = tab_left_ff - 1'b1;
            if (tab_left_ff == TAB_W'(1)) begin
               respond  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_COPY: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(VISIBLE_CELLS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The last copied cell is written here; cnt already points at the hidden row.
            if (scroll_ff) begin
               state_in = ST_HCLR;
            end else begin
               respond  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_HCLR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SHADOW_CELLS - 1)) begin
               respond  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            respond = 1'b1;
            if (in_range_ff) begin
               rsp_char_in = dp_rd_data.chr;
               rsp_attr_in = dp_rd_data.attr;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = respond;
      rsp_row_in   = ROW_FW'(row_in);
      rsp_col_in   = COL_FW'(col_in);
   end

   // Control register writes.
   always_comb begin
      attr_in = attr_ff;
      tabs_in = tabs_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ATTRIBUTE:  attr_in = csr_data[ATTR_W-1:0];
            CSR_TAB_SPACES: tabs_in = csr_data[TAB_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_ff       <= '0;
         col_ff       <= '0;
         attr_ff      <= ATTR_RESET;
         tabs_ff      <= TAB_RESET;
         tab_left_ff  <= '0;
         cnt_ff       <= '0;
         scroll_ff    <= 1'b0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         attr_ff      <= attr_in;
         tabs_ff      <= tabs_in;
         tab_left_ff  <= tab_left_in;
         cnt_ff       <= cnt_in;
         scroll_ff    <= scroll_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_range_ff <= in_range_in;
      pa_ff       <= pa_in;
      rsp_char_ff <= rsp_char_in;
      rsp_attr_ff <= rsp_attr_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cell_char      = rsp_char_ff;
   assign rsp_cell_attribute = rsp_attr_ff;
   assign rsp_cursor_row     = rsp_row_ff;
   assign rsp_cursor_col     = rsp_col_ff;

endmodule

`default_nettype wire

>>> rtl/core/tcw_checker.sv
`default_nettype none

module tcw_checker #(
   parameter int SCREEN_COLS = 80
) (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           start,
   input wire logic                           busy,
   input wire logic                           req_command,
   input wire logic [tcw_pkg::CHAR_W-1:0]     req_char_code,
   input wire logic                           rsp_valid,
   input wire logic [tcw_pkg::CHAR_W-1:0]     rsp_cell_char,
   input wire logic [tcw_pkg::ATTR_W-1:0]     rsp_cell_attribute,
   input wire logic [tcw_pkg::COL_FW-1:0]     rsp_cursor_col
);

   import tcw_pkg::*;

   // The clearing pass holds off commands right after reset.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("busy low right after reset");

   // An accepted command either answers next cycle or keeps the block busy.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted command made no progress");

   // A response only appears once the command has finished.
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while still busy");

   // The cursor column never leaves the screen.
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cursor_col < SCREEN_COLS))
      else $error("cursor column out of range");

   // A plain character write answers next cycle with an empty cell.
   a_write_beat: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_command == CMD_WRITE) && (req_char_code != CH_NEWLINE) &&
       (req_char_code != CH_TAB) && (req_char_code != CH_NUL))
      |=> (rsp_valid && (rsp_cell_char == '0) && (rsp_cell_attribute == '0)))
      else $error("character write beat wrong");

endmodule

bind text_console_writer tcw_checker #(
   .SCREEN_COLS (SCREEN_COLS)
) u_tcw_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_command        (req_command),
   .req_char_code      (req_char_code),
   .rsp_valid          (rsp_valid),
   .rsp_cell_char      (rsp_cell_char),
   .rsp_cell_attribute (rsp_cell_attribute),
   .rsp_cursor_col     (rsp_cursor_col)
);

`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tcw_pkg::*;

   localparam int ROWS         = 25;
   localparam int COLS         = 80;
   localparam int VISIBLE      = ROWS * COLS;
   localparam int SHADOW       = (ROWS + 1) * COLS;
   localparam int PHASES       = 7;
   localparam int PHASE_ITEMS  = 34;
   // A newline with a scroll is the longest command and the clearing pass after reset runs
   // about as long, so this leaves a wide margin.
   localparam int IDLE_LIMIT   = 12000;
   localparam int DRAIN_CYCLES = 100;

   // One response beat as the console reports it.
   typedef struct packed {
      logic [CHAR_W-1:0] chr;
      logic [ATTR_W-1:0] attr;
      logic [ROW_FW-1:0] row;
      logic [COL_FW-1:0] col;
   } reply_type;

   // Tracks the console's buffers and cursor and holds the responses still owed.
   class screen_tracker_type;
      cell_type          shadow [SHADOW];
      cell_type          display [VISIBLE];
      int                cur_row;
      int                cur_col;
      logic [ATTR_W-1:0] attr_reg;
      logic [TAB_W-1:0]  tab_reg;
      reply_type         owed_replies [$];
      int                errors;

      function new();
         foreach (shadow[i]) shadow[i] = '0;
         foreach (display[i]) display[i] = '0;
         cur_row  = 0;
         cur_col  = 0;
         attr_reg = ATTR_RESET;
         tab_reg  = TAB_RESET;
         errors   = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_ATTRIBUTE: attr_reg = data[ATTR_W-1:0];
            CSR_TAB_SPACES: tab_reg = data[TAB_W-1:0];
            default: ;
         endcase
      endfunction

      // Store one byte at the cursor; the next-to-last column shows a dot and the
      // last column swallows the byte.
      function void place_char(logic [CHAR_W-1:0] ch);
         cell_type c;
         if (cur_col <= COLS - 2) begin
            c.attr = attr_reg;
            c.chr  = (cur_col == COLS - 2) ? CH_DOT : ch;
            shadow[cur_row * COLS + cur_col] = c;
         end
         if (cur_col < COLS - 1) cur_col++;
      endfunction

      // Advance or scroll, then publish the visible rows.
      function void advance_line();
         if (cur_row >= ROWS) begin
            for (int i = 0; i < VISIBLE; i++) shadow[i] = shadow[i + COLS];
            for (int i = VISIBLE; i < SHADOW; i++) shadow[i] = '0;
            cur_row = ROWS;
         end else begin
            cur_row++;
         end
         cur_col = 0;
         for (int i = 0; i < VISIBLE; i++) display[i] = shadow[i];
      endfunction

      function void note_command(logic cmd, logic [CHAR_W-1:0] ch, logic [ROW_FW-1:0] rr,
                                 logic [COL_FW-1:0] rc);
         reply_type r;
         cell_type  c;
         r = '0;
         if (cmd == CMD_WRITE) begin
            if (ch == CH_NEWLINE) begin
               advance_line();
            end else if (ch == CH_TAB) begin
               for (int i = 0; i < int'(tab_reg); i++) place_char(CH_SPACE);
            end else if (ch != CH_NUL) begin
               place_char(ch);
            end
         end else if (rr < ROWS && rc < COLS) begin
            c      = display[int'(rr) * COLS + int'(rc)];
            r.chr  = c.chr;
            r.attr = c.attr;
         end
         r.row = ROW_FW'(cur_row);
         r.col = COL_FW'(cur_col);
         owed_replies.push_back(r);
      endfunction

      function void check_response(logic [CHAR_W-1:0] chr, logic [ATTR_W-1:0] attr,
                                   logic [ROW_FW-1:0] row, logic [COL_FW-1:0] col);
         reply_type want;
         if (owed_replies.size() == 0) begin
            $error("unexpected response: char %0d attribute %0d row %0d col %0d",
                   chr, attr, row, col);
            errors++;
            return;
         end
         want = owed_replies.pop_front();
         if (chr !== want.chr) begin
            $error("cell_char: expected %0d, got %0d", want.chr, chr);
            errors++;
         end
         if (attr !== want.attr) begin
            $error("cell_attribute: expected %0d, got %0d", want.attr, attr);
            errors++;
         end
         if (row !== want.row) begin
            $error("cursor_row: expected %0d, got %0d", want.row, row);
            errors++;
         end
         if (col !== want.col) begin
            $error("cursor_col: expected %0d, got %0d", want.col, col);
            errors++;
         end
      endfunction
   endclass

   logic                  clock              = 1'b0;
   logic                  reset              = 1'b1;
   logic                  start              = 1'b0;
   logic                  busy;
   logic                  req_command        = CMD_WRITE;
   logic [CHAR_W-1:0]     req_char_code      = '0;
   logic [ROW_FW-1:0]     req_read_row       = '0;
   logic [COL_FW-1:0]     req_read_col       = '0;
   logic                  rsp_valid;
   logic [CHAR_W-1:0]     rsp_cell_char;
   logic [ATTR_W-1:0]     rsp_cell_attribute;
   logic [ROW_FW-1:0]     rsp_cursor_row;
   logic [COL_FW-1:0]     rsp_cursor_col;
   logic                  csr_valid          = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index          = CSR_ATTRIBUTE;
   logic [CSR_DATA_W-1:0] csr_data           = '0;

   screen_tracker_type tracker;
   int                 burst_left  = 0;
   int                 items_sent  = 0;
   int                 idle_cycles = 0;

   always #10 clock = ~clock;

   text_console_writer #(
      .SCREEN_ROWS(ROWS),
      .SCREEN_COLS(COLS)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_char_code      (req_char_code),
      .req_read_row       (req_read_row),
      .req_read_col       (req_read_col),
      .rsp_valid          (rsp_valid),
      .rsp_cell_char      (rsp_cell_char),
      .rsp_cell_attribute (rsp_cell_attribute),
      .rsp_cursor_row     (rsp_cursor_row),
      .rsp_cursor_col     (rsp_cursor_col),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // Observe every beat at the rising edge and watch for a hang.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            tracker.check_response(rsp_cell_char, rsp_cell_attribute, rsp_cursor_row,
                                   rsp_cursor_col);
         if (start && !busy)
            tracker.note_command(req_command, req_char_code, req_read_row, req_read_col);
         if (csr_valid && csr_ready)
            tracker.write_register(csr_index, csr_data);
         if (rsp_valid || (start && !busy) || (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
         end
      end
   end

   // Present one command, holding it until the console takes it. Commands go out
   // in bursts separated by random gaps.
   task automatic send_command(input logic cmd, input logic [CHAR_W-1:0] ch,
                               input logic [ROW_FW-1:0] rr, input logic [COL_FW-1:0] rc);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      start         <= 1'b1;
      req_command   <= cmd;
      req_char_code <= ch;
      req_read_row  <= rr;
      req_read_col  <= rc;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   // Unused fields carry random values so that their bits move too.
   task automatic write_char(input logic [CHAR_W-1:0] ch);
      send_command(CMD_WRITE, ch, ROW_FW'($urandom), COL_FW'($urandom));
   endtask

   task automatic read_cell(input int rr, input int rc);
      send_command(CMD_READ, CHAR_W'($urandom), ROW_FW'(rr), COL_FW'(rc));
   endtask

   function automatic logic [CHAR_W-1:0] random_printable();
      int ch;
      do ch = $urandom_range(1, 255); while (ch == CH_TAB || ch == CH_NEWLINE);
      return CHAR_W'(ch);
   endfunction

   // Reads often land on the last published line, the rest spread over the screen, some out of range.
   task automatic random_read();
      int rr;
      int rc;
      int near_row;
      near_row = (tracker.cur_row > 0) ? tracker.cur_row - 1 : 0;
      case ($urandom_range(0, 9))
         0: begin
            rr = $urandom_range(ROWS, 31);
            rc = $urandom_range(0, 127);
         end
         1: begin
            rr = $urandom_range(0, 31);
            rc = $urandom_range(COLS, 127);
         end
         2, 3, 4: begin
            rr = near_row;
            rc = $urandom_range(0, COLS - 1);
         end
         5: begin
            rr = near_row;
            rc = $urandom_range(COLS - 4, COLS - 1);
         end
         default: begin
            rr = $urandom_range(0, ROWS - 1);
            rc = $urandom_range(0, COLS - 1);
         end
      endcase
      read_cell(rr, rc);
   endtask

   // One line of text: short or long, mixed with tabs, zero bytes and reads,
   // usually closed by a newline. Now and then a run of blank lines instead.
   task automatic random_line();
      int pick;
      int len;
      int kind;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         repeat ($urandom_range(4, 14)) write_char(CH_NEWLINE);
         return;
      end
      len = (pick < 30) ? $urandom_range(50, 95) : $urandom_range(0, 8);
      for (int k = 0; k < len; k++) begin
         kind = $urandom_range(0, 99);
         if (kind < 55) write_char(random_printable());
         else if (kind < 66) write_char(CH_TAB);
         else if (kind < 70) write_char(CH_NUL);
         else random_read();
      end
      if ($urandom_range(0, 9) != 0) write_char(CH_NEWLINE);
   endtask

   // Drop start and wait until every owed response has arrived.
   task automatic quiesce();
      @(negedge clock);
      start <= 1'b0;
      while (tracker.owed_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // The tab count register ignores its upper data bits; drive them at random.
   task automatic configure(input logic [ATTR_W-1:0] attr, input logic [TAB_W-1:0] tabs);
      quiesce();
      write_register(CSR_ATTRIBUTE, attr);
      write_register(CSR_TAB_SPACES, {4'($urandom), tabs});
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int phase_start;
      tracker = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reads of a blank screen, edge bytes, a zero byte, then tabs
      // that run into the dot column and the dropped last column.
      read_cell(0, 0);
      read_cell(31, 127);
      read_cell(ROWS - 1, COLS - 1);
      write_char(8'd65);
      write_char(8'd255);
      write_char(8'd128);
      write_char(CH_NUL);
      repeat (10) write_char(CH_TAB);
      write_char(8'd90);
      write_char(CH_NEWLINE);
      read_cell(0, 0);
      read_cell(0, 1);
      read_cell(0, 25);
      read_cell(0, COLS - 2);
      read_cell(0, COLS - 1);
      read_cell(1, 0);

      // Random phases, each under its own attribute and tab setting.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: configure(8'd0, 4'd0);
            1: configure(8'd255, 4'd15);
            3: configure(ATTR_RESET, 4'd1);
            default: configure(ATTR_W'($urandom), TAB_W'($urandom));
         endcase
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) random_line();
      end

      quiesce();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
